>>> design/dual_window_min_max_tracker_top_macros.svh
// ----------------------------------------------------------------------------
// dual window min/max tracker assertion macros
// shared property forms for the tracker's checks
// ----------------------------------------------------------------------------
`ifndef DUAL_WINDOW_MIN_MAX_TRACKER_TOP_MACROS_SVH
`define DUAL_WINDOW_MIN_MAX_TRACKER_TOP_MACROS_SVH

// same-cycle implication
`define DWMM_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DWMM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/dwmm_pkg.sv
// ----------------------------------------------------------------------------
// dwmm_pkg
// shared constants and types of the dual window min/max tracker
// ----------------------------------------------------------------------------
package dwmm_pkg;

   localparam int MAX_WINDOW_DEFAULT  = 128;
   localparam int SAMPLE_BITS_DEFAULT = 16;
   localparam int LANE_COUNT          = 8;

   localparam int CSR_DATA_BITS  = 8;
   localparam int CSR_INDEX_BITS = 1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SMALL_WINDOW = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LARGE_WINDOW = 1'b1;

   localparam logic [CSR_DATA_BITS-1:0] SMALL_WINDOW_RESET = 8'd10;
   localparam logic [CSR_DATA_BITS-1:0] LARGE_WINDOW_RESET = 8'd100;

   // result slots: bit 0 min, bit 1 short window, bit 2 ask channel
   localparam int RES_COUNT         = 8;
   localparam int RES_BID_MAX_LONG  = 0;
   localparam int RES_BID_MIN_LONG  = 1;
   localparam int RES_BID_MAX_SHORT = 2;
   localparam int RES_BID_MIN_SHORT = 3;
   localparam int RES_ASK_MAX_LONG  = 4;
   localparam int RES_ASK_MIN_LONG  = 5;
   localparam int RES_ASK_MAX_SHORT = 6;
   localparam int RES_ASK_MIN_SHORT = 7;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic shift_in;
      logic rotate;
   } hist_ctrl_type;

   typedef struct packed {
      logic clear;
      logic scan;
   } lane_ctrl_type;

endpackage

>>> design/dwmm_hist.sv
// ----------------------------------------------------------------------------
// dwmm_hist
// sample history shift line, split into lane segments that rotate during a scan
// ----------------------------------------------------------------------------
module dwmm_hist
   import dwmm_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT,
   parameter int LANES       = LANE_COUNT,
   parameter int STEPS       = 16
) (
   input  logic                              clock,
   input  hist_ctrl_type                     ctrl,
   input  logic [SAMPLE_BITS-1:0]            bid_in,
   input  logic [SAMPLE_BITS-1:0]            ask_in,
   output logic [LANES-1:0][SAMPLE_BITS-1:0] bid_head,
   output logic [LANES-1:0][SAMPLE_BITS-1:0] ask_head
);

   localparam int DEPTH = LANES * STEPS;

   logic [SAMPLE_BITS-1:0] bid_ff [DEPTH];
   logic [SAMPLE_BITS-1:0] ask_ff [DEPTH];

   // newest sample at index 0; each segment rotates toward its head
   always_ff @(posedge clock) begin
      if (ctrl.shift_in) begin
         bid_ff[0] <= bid_in;
         ask_ff[0] <= ask_in;
         for (int i = 1; i < DEPTH; i++) begin
            bid_ff[i] <= bid_ff[i-1];
            ask_ff[i] <= ask_ff[i-1];
         end
      end else if (ctrl.rotate) begin
         for (int l = 0; l < LANES; l++) begin
            for (int j = 0; j < STEPS - 1; j++) begin
               bid_ff[l*STEPS+j] <= bid_ff[l*STEPS+j+1];
               ask_ff[l*STEPS+j] <= ask_ff[l*STEPS+j+1];
            end
            bid_ff[l*STEPS+STEPS-1] <= bid_ff[l*STEPS];
            ask_ff[l*STEPS+STEPS-1] <= ask_ff[l*STEPS];
         end
      end
   end

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         bid_head[l] = bid_ff[l*STEPS];
         ask_head[l] = ask_ff[l*STEPS];
      end
   end

endmodule

>>> design/dwmm_lane.sv
// ----------------------------------------------------------------------------
// dwmm_lane
// per-lane running max/min of both channels over both windows
// ----------------------------------------------------------------------------
module dwmm_lane
   import dwmm_pkg::*;
#(
   parameter int MAX_WINDOW  = MAX_WINDOW_DEFAULT,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT,
   parameter int LANE_BASE   = 0,
   parameter int STEPS       = 16,
   parameter int STEP_BITS   = 4,
   parameter int SPAN_BITS   = 8
) (
   input  logic                                  clock,
   input  lane_ctrl_type                         ctrl,
   input  logic [STEP_BITS-1:0]                  step,
   input  logic [SPAN_BITS-1:0]                  span_long,
   input  logic [SPAN_BITS-1:0]                  span_short,
   input  logic [SAMPLE_BITS-1:0]                bid_head,
   input  logic [SAMPLE_BITS-1:0]                ask_head,
   output logic [RES_COUNT-1:0][SAMPLE_BITS-1:0] result
);

   localparam int DEPTH_BITS = $clog2(STEPS * ((MAX_WINDOW + STEPS - 1) / STEPS));
   localparam int AGE_BITS   = (DEPTH_BITS > SPAN_BITS) ? DEPTH_BITS : SPAN_BITS;

   localparam logic [SAMPLE_BITS-1:0] MOST_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam logic [SAMPLE_BITS-1:0] MOST_POS = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

   logic [RES_COUNT-1:0][SAMPLE_BITS-1:0] acc_ff;
   logic [RES_COUNT-1:0][SAMPLE_BITS-1:0] acc_in;
   logic [AGE_BITS-1:0]                   age;
   logic                                  in_long;
   logic                                  in_short;

   assign age      = AGE_BITS'(LANE_BASE) + AGE_BITS'(step);
   assign in_long  = age < AGE_BITS'(span_long);
   assign in_short = age < AGE_BITS'(span_short);

   always_comb begin
      logic [SAMPLE_BITS-1:0] v;
      logic                   hit;
      for (int k = 0; k < RES_COUNT; k++) begin
         v   = ((k / 4) == 1) ? ask_head : bid_head;
         hit = (((k / 2) % 2) == 1) ? in_short : in_long;
         acc_in[k] = acc_ff[k];
         if (ctrl.clear) begin
            acc_in[k] = ((k % 2) == 1) ? MOST_POS : MOST_NEG;
         end else if (ctrl.scan && hit) begin
            if ((k % 2) == 1) begin
               if ($signed(v) < $signed(acc_ff[k])) acc_in[k] = v;
            end else begin
               if ($signed(v) > $signed(acc_ff[k])) acc_in[k] = v;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign result = acc_ff;

endmodule

>>> design/dwmm_merge.sv
// ----------------------------------------------------------------------------
// dwmm_merge
// combines the lane extremes into the final max/min set
// ----------------------------------------------------------------------------
module dwmm_merge
   import dwmm_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT,
   parameter int LANES       = LANE_COUNT
) (
   input  logic [LANES-1:0][RES_COUNT-1:0][SAMPLE_BITS-1:0] lane_result,
   output logic [RES_COUNT-1:0][SAMPLE_BITS-1:0]            merged
);

   always_comb begin
      merged = lane_result[0];
      for (int l = 1; l < LANES; l++) begin
         for (int k = 0; k < RES_COUNT; k++) begin
            if ((k % 2) == 1) begin
               if ($signed(lane_result[l][k]) < $signed(merged[k]))
                  merged[k] = lane_result[l][k];
            end else begin
               if ($signed(lane_result[l][k]) > $signed(merged[k]))
                  merged[k] = lane_result[l][k];
            end
         end
      end
   end

endmodule

>>> design/dual_window_min_max_tracker_top.sv
// ----------------------------------------------------------------------------
// dual_window_min_max_tracker_top
// sliding-window max/min of bid and ask samples over a short and a long window
//
// req channel: one beat carries a bid and an ask sample and a start flag that
// empties the history before the sample is stored. rsp channel: one beat per
// req beat with max and min of both channels over both windows, the current
// sample included; a window not yet filled covers the samples held so far.
// csr port: index 0 short window, index 1 long window, written while idle;
// 0 acts as 1 and values above MAX_WINDOW act as MAX_WINDOW.
// timing: the history is split into LANE_COUNT lanes of S = MAX_WINDOW /
// LANE_COUNT entries (rounded up); the lanes scan one entry each per cycle, and
// rsp_valid rises once the scan is done and the result is loaded. req_stall
// stays high from an accepted req beat until its result enters the rsp register.
// reset: windows return to 10 and 100, the history counts as empty, no rsp
// beat pending. a stalled rsp beat holds while the next item is scanned; the
// finished result then waits in the merge stage until the rsp register frees.
// ----------------------------------------------------------------------------
module dual_window_min_max_tracker_top
   import dwmm_pkg::*;
#(
   parameter int MAX_WINDOW  = MAX_WINDOW_DEFAULT,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_start_of_series,
   input  logic signed [SAMPLE_BITS-1:0] req_bid_sample,
   input  logic signed [SAMPLE_BITS-1:0] req_ask_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_bid_max_long,
   output logic signed [SAMPLE_BITS-1:0] rsp_bid_min_long,
   output logic signed [SAMPLE_BITS-1:0] rsp_bid_max_short,
   output logic signed [SAMPLE_BITS-1:0] rsp_bid_min_short,
   output logic signed [SAMPLE_BITS-1:0] rsp_ask_max_long,
   output logic signed [SAMPLE_BITS-1:0] rsp_ask_min_long,
   output logic signed [SAMPLE_BITS-1:0] rsp_ask_max_short,
   output logic signed [SAMPLE_BITS-1:0] rsp_ask_min_short,
   input  logic                          csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_write_data
);

   localparam int LANES     = (MAX_WINDOW < LANE_COUNT) ? MAX_WINDOW : LANE_COUNT;
   localparam int STEPS     = (MAX_WINDOW + LANES - 1) / LANES;
   localparam int STEP_BITS = (STEPS > 1) ? $clog2(STEPS) : 1;
   localparam int SPAN_BITS = $clog2(MAX_WINDOW + 1);
   localparam int CMP_BITS  = (SPAN_BITS > CSR_DATA_BITS) ? SPAN_BITS : CSR_DATA_BITS;

   state_type                             state_ff, state_in;
   logic [STEP_BITS-1:0]                  step_ff, step_in;
   logic [SPAN_BITS-1:0]                  held_ff, held_in;
   logic [SPAN_BITS-1:0]                  span_long_ff, span_long_in;
   logic [SPAN_BITS-1:0]                  span_short_ff, span_short_in;
   logic [CSR_DATA_BITS-1:0]              small_window_ff, small_window_in;
   logic [CSR_DATA_BITS-1:0]              large_window_ff, large_window_in;
   logic                                  rsp_valid_ff, rsp_valid_in;
   logic [RES_COUNT-1:0][SAMPLE_BITS-1:0] rsp_data_ff, rsp_data_in;

   logic                                  req_accept;
   logic                                  out_load;
   hist_ctrl_type                         hist_ctrl;
   lane_ctrl_type                         lane_ctrl;
   logic [LANES-1:0][SAMPLE_BITS-1:0]     bid_head;
   logic [LANES-1:0][SAMPLE_BITS-1:0]     ask_head;
   logic [LANES-1:0][RES_COUNT-1:0][SAMPLE_BITS-1:0] lane_result;
   logic [RES_COUNT-1:0][SAMPLE_BITS-1:0] merged;

   function automatic logic [SPAN_BITS-1:0] span_of(
      input logic [CSR_DATA_BITS-1:0] w,
      input logic [SPAN_BITS-1:0]     held
   );
      logic [CMP_BITS-1:0] n;
      n = CMP_BITS'(w);
      if (n == '0) n = CMP_BITS'(1);
      if (n > CMP_BITS'(MAX_WINDOW)) n = CMP_BITS'(MAX_WINDOW);
      if (n > CMP_BITS'(held)) n = CMP_BITS'(held);
      return SPAN_BITS'(n);
   endfunction

   // csr writes
   always_comb begin
      small_window_in = small_window_ff;
      large_window_in = large_window_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_SMALL_WINDOW: small_window_in = csr_write_data;
            CSR_LARGE_WINDOW: large_window_in = csr_write_data;
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      held_in       = held_ff;
      span_long_in  = span_long_ff;
      span_short_in = span_short_ff;
      req_stall     = 1'b1;
      req_accept    = 1'b0;
      out_load      = 1'b0;
      hist_ctrl     = '0;
      lane_ctrl     = '0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               req_accept = 1'b1;
               if (req_start_of_series) begin
                  held_in = SPAN_BITS'(1);
               end else if (held_ff < SPAN_BITS'(MAX_WINDOW)) begin
                  held_in = held_ff + SPAN_BITS'(1);
               end
               span_long_in       = span_of(large_window_ff, held_in);
               span_short_in      = span_of(small_window_ff, held_in);
               hist_ctrl.shift_in = 1'b1;
               lane_ctrl.clear    = 1'b1;
               step_in            = '0;
               state_in           = ST_SCAN;
            end
         end
         ST_SCAN: begin
            hist_ctrl.rotate = 1'b1;
            lane_ctrl.scan   = 1'b1;
            step_in          = step_ff + STEP_BITS'(1);
            if (step_ff == STEP_BITS'(STEPS - 1)) begin
               step_in  = '0;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = out_load | (rsp_valid_ff & rsp_stall);
   assign rsp_data_in  = out_load ? merged : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         step_ff         <= '0;
         held_ff         <= '0;
         span_long_ff    <= '0;
         span_short_ff   <= '0;
         small_window_ff <= SMALL_WINDOW_RESET;
         large_window_ff <= LARGE_WINDOW_RESET;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         step_ff         <= step_in;
         held_ff         <= held_in;
         span_long_ff    <= span_long_in;
         span_short_ff   <= span_short_in;
         small_window_ff <= small_window_in;
         large_window_ff <= large_window_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   dwmm_hist #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .LANES       (LANES),
      .STEPS       (STEPS)
   ) u_hist (
      .clock    (clock),
      .ctrl     (hist_ctrl),
      .bid_in   (req_bid_sample),
      .ask_in   (req_ask_sample),
      .bid_head (bid_head),
      .ask_head (ask_head)
   );

   for (genvar l = 0; l < LANES; l++) begin : g_lane
      dwmm_lane #(
         .MAX_WINDOW  (MAX_WINDOW),
         .SAMPLE_BITS (SAMPLE_BITS),
         .LANE_BASE   (l * STEPS),
         .STEPS       (STEPS),
         .STEP_BITS   (STEP_BITS),
         .SPAN_BITS   (SPAN_BITS)
      ) u_lane (
         .clock      (clock),
         .ctrl       (lane_ctrl),
         .step       (step_ff),
         .span_long  (span_long_ff),
         .span_short (span_short_ff),
         .bid_head   (bid_head[l]),
         .ask_head   (ask_head[l]),
         .result     (lane_result[l])
      );
   end

   dwmm_merge #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .LANES       (LANES)
   ) u_merge (
      .lane_result (lane_result),
      .merged      (merged)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_bid_max_long  = rsp_data_ff[RES_BID_MAX_LONG];
   assign rsp_bid_min_long  = rsp_data_ff[RES_BID_MIN_LONG];
   assign rsp_bid_max_short = rsp_data_ff[RES_BID_MAX_SHORT];
   assign rsp_bid_min_short = rsp_data_ff[RES_BID_MIN_SHORT];
   assign rsp_ask_max_long  = rsp_data_ff[RES_ASK_MAX_LONG];
   assign rsp_ask_min_long  = rsp_data_ff[RES_ASK_MIN_LONG];
   assign rsp_ask_max_short = rsp_data_ff[RES_ASK_MAX_SHORT];
   assign rsp_ask_min_short = rsp_data_ff[RES_ASK_MIN_SHORT];

   `include "dual_window_min_max_tracker_top_macros.svh"

   `DWMM_ASSERT_NEXT(a_accept_starts_scan, req_valid && !req_stall, state_ff == ST_SCAN, "accepted beat did not start a scan")
   `DWMM_ASSERT_NEXT(a_done_holds_when_blocked, state_ff == ST_DONE && rsp_valid_ff && rsp_stall, state_ff == ST_DONE, "merged result dropped while rsp stalled")
   `DWMM_ASSERT_NOW(a_held_in_range, 1'b1, held_ff <= SPAN_BITS'(MAX_WINDOW), "sample count above window depth")
   `DWMM_ASSERT_NOW(a_spans_nonzero, state_ff == ST_SCAN, span_long_ff != '0 && span_short_ff != '0, "empty window during scan")

endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// checks the dual window min/max tracker against an in-bench ring predictor
//
// each req beat is folded into a copy of the bid and ask history rings and
// the expected max and min over both windows are queued; each rsp beat is
// compared field by field with the oldest entry. directed beats cover sample
// extremes, the start flag and zero and oversized windows; random series of
// short and long lengths then run under several window settings, with random
// gaps on req, random stalls on rsp and a stretch with neither.
// ----------------------------------------------------------------------------
module tb;
   import dwmm_pkg::*;

   localparam int RING_DEPTH  = MAX_WINDOW_DEFAULT;
   localparam int STALL_LIMIT = 2000;

   typedef logic signed [SAMPLE_BITS_DEFAULT-1:0] sample_type;
   typedef logic [$clog2(RING_DEPTH)-1:0] ring_index_type;

   typedef struct packed {
      sample_type bid_max_long;
      sample_type bid_min_long;
      sample_type bid_max_short;
      sample_type bid_min_short;
      sample_type ask_max_long;
      sample_type ask_min_long;
      sample_type ask_max_short;
      sample_type ask_min_short;
   } window_extremes_type;

   localparam sample_type SAMPLE_MOST = 16'sh7fff;
   localparam sample_type SAMPLE_LEAST = 16'sh8000;
   localparam sample_type CORNER_SAMPLES [4] = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'shffff};

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic                        req_start_of_series = 1'b0;
   sample_type                  req_bid_sample = '0;
   sample_type                  req_ask_sample = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   sample_type                  rsp_bid_max_long;
   sample_type                  rsp_bid_min_long;
   sample_type                  rsp_bid_max_short;
   sample_type                  rsp_bid_min_short;
   sample_type                  rsp_ask_max_long;
   sample_type                  rsp_ask_min_long;
   sample_type                  rsp_ask_max_short;
   sample_type                  rsp_ask_min_short;
   logic                        csr_write_enable = 1'b0;
   logic [CSR_INDEX_BITS-1:0]   csr_index = CSR_SMALL_WINDOW;
   logic [CSR_DATA_BITS-1:0]    csr_write_data = '0;

   // predictor state
   sample_type                  bid_ring [RING_DEPTH];
   sample_type                  ask_ring [RING_DEPTH];
   ring_index_type              ring_slot = '0;
   int                          ring_fill = 0;
   logic [CSR_DATA_BITS-1:0]    short_window = SMALL_WINDOW_RESET;
   logic [CSR_DATA_BITS-1:0]    long_window = LARGE_WINDOW_RESET;
   window_extremes_type         pending_extremes [$];

   int  mismatch_count = 0;
   int  result_count = 0;
   int  quiet_cycles = 0;
   int  stall_burst = 0;
   bit  sender_idle_on = 1'b1;
   bit  rsp_idle_on = 1'b1;

   dual_window_min_max_tracker_top u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_start_of_series (req_start_of_series),
      .req_bid_sample      (req_bid_sample),
      .req_ask_sample      (req_ask_sample),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_bid_max_long    (rsp_bid_max_long),
      .rsp_bid_min_long    (rsp_bid_min_long),
      .rsp_bid_max_short   (rsp_bid_max_short),
      .rsp_bid_min_short   (rsp_bid_min_short),
      .rsp_ask_max_long    (rsp_ask_max_long),
      .rsp_ask_min_long    (rsp_ask_min_long),
      .rsp_ask_max_short   (rsp_ask_max_short),
      .rsp_ask_min_short   (rsp_ask_min_short),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string text);
      mismatch_count++;
      if (mismatch_count <= 50) begin
         $display("error: %s", text);
      end
   endtask

   task automatic check_field(input string name, input sample_type got, input sample_type want);
      if (got !== want) begin
         report_mismatch($sformatf("rsp beat %0d %s: got %0d expected %0d",
                                   result_count, name, got, want));
      end
   endtask

   function automatic int covered_span(input logic [CSR_DATA_BITS-1:0] window);
      int n;
      n = (window == 0) ? 1 : int'(window);
      if (n > RING_DEPTH) n = RING_DEPTH;
      if (n > ring_fill) n = ring_fill;
      return n;
   endfunction

   // fold one sample pair into the rings and queue the window extremes
   task automatic record_sample(input logic start, input sample_type bid, input sample_type ask);
      window_extremes_type want;
      ring_index_type      top;
      ring_index_type      idx;
      sample_type          b;
      sample_type          a;
      int                  long_n;
      int                  short_n;
      int                  scan_n;
      if (start) begin
         ring_fill = 0;
         ring_slot = '0;
      end
      top = ring_slot;
      bid_ring[top] = bid;
      ask_ring[top] = ask;
      ring_slot = top + 1'b1;
      if (ring_fill < RING_DEPTH) ring_fill++;
      long_n = covered_span(long_window);
      short_n = covered_span(short_window);
      scan_n = (long_n > short_n) ? long_n : short_n;
      want.bid_max_long  = SAMPLE_LEAST;
      want.bid_min_long  = SAMPLE_MOST;
      want.bid_max_short = SAMPLE_LEAST;
      want.bid_min_short = SAMPLE_MOST;
      want.ask_max_long  = SAMPLE_LEAST;
      want.ask_min_long  = SAMPLE_MOST;
      want.ask_max_short = SAMPLE_LEAST;
      want.ask_min_short = SAMPLE_MOST;
      for (int k = 0; k < scan_n; k++) begin
         idx = top - ring_index_type'(k);
         b = bid_ring[idx];
         a = ask_ring[idx];
         if (k < long_n) begin
            if (b > want.bid_max_long) want.bid_max_long = b;
            if (b < want.bid_min_long) want.bid_min_long = b;
            if (a > want.ask_max_long) want.ask_max_long = a;
            if (a < want.ask_min_long) want.ask_min_long = a;
         end
         if (k < short_n) begin
            if (b > want.bid_max_short) want.bid_max_short = b;
            if (b < want.bid_min_short) want.bid_min_short = b;
            if (a > want.ask_max_short) want.ask_max_short = a;
            if (a < want.ask_min_short) want.ask_min_short = a;
         end
      end
      pending_extremes.push_back(want);
   endtask

   task automatic send_sample(input logic start, input sample_type bid, input sample_type ask);
      @(negedge clock);
      if (sender_idle_on && $urandom_range(99) < 11) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(24, 1)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_start_of_series <= start;
      req_bid_sample <= bid;
      req_ask_sample <= ask;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      record_sample(start, bid, ask);
   endtask

   // stop sending and wait for every queued result
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_extremes.size() != 0) @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_window(input logic [CSR_INDEX_BITS-1:0] index,
                               input logic [CSR_DATA_BITS-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= value;
      @(posedge clock);
      if (index == CSR_SMALL_WINDOW) short_window = value;
      else long_window = value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic sample_type random_sample();
      int pick;
      pick = $urandom_range(7);
      if (pick == 0) return CORNER_SAMPLES[$urandom_range(3)];
      if (pick < 3) return sample_type'(int'($urandom_range(8)) - 4);
      return sample_type'($urandom);
   endfunction

   function automatic logic [CSR_DATA_BITS-1:0] random_window();
      case ($urandom_range(5))
         0: return 8'd0;
         1: return 8'd1;
         2: return 8'd128;
         3: return 8'($urandom_range(255, 129));
         default: return 8'($urandom_range(127, 2));
      endcase
   endfunction

   // series of random length, a start beat on each and a stray start now and then
   task automatic send_random_series(input int beats);
      int left;
      int series_len;
      left = beats;
      while (left > 0) begin
         series_len = ($urandom_range(9) == 0) ? $urandom_range(300, 129) : $urandom_range(40, 1);
         for (int i = 0; i < series_len && left > 0; i++) begin
            send_sample((i == 0) || ($urandom_range(49) == 0), random_sample(), random_sample());
            left--;
         end
      end
   endtask

   task automatic test_reset_windows();
      send_sample(1'b1, 16'sh7fff, 16'sh8000);
      send_sample(1'b0, 16'sh8000, 16'sh7fff);
      send_sample(1'b0, 16'sh0000, 16'shffff);
      send_sample(1'b0, 16'shffff, 16'sh0000);
      send_sample(1'b0, 16'sh5555, 16'shaaaa);
      send_sample(1'b0, 16'shaaaa, 16'sh5555);
      send_sample(1'b0, 16'sd1, -16'sd2);
      send_sample(1'b0, -16'sd2, 16'sd1);
      send_sample(1'b0, 16'sd100, 16'sd100);
      send_sample(1'b0, 16'sd100, 16'sd100);
      send_sample(1'b0, -16'sd100, 16'sd50);
      send_sample(1'b0, 16'sd12, 16'sd13);
      send_sample(1'b1, 16'sd7, -16'sd7);
      send_sample(1'b0, 16'sh7fff, 16'sh7fff);
   endtask

   task automatic test_zero_windows();
      drain_results();
      write_window(CSR_SMALL_WINDOW, 8'd0);
      write_window(CSR_LARGE_WINDOW, 8'd0);
      send_sample(1'b1, -16'sd5, 16'sd5);
      send_sample(1'b0, 16'sd5, -16'sd5);
      send_sample(1'b0, 16'sh8000, 16'sh7fff);
      send_sample(1'b1, 16'sd0, 16'sd0);
   endtask

   task automatic test_oversized_windows();
      drain_results();
      write_window(CSR_SMALL_WINDOW, 8'd255);
      write_window(CSR_LARGE_WINDOW, 8'd129);
      send_sample(1'b0, 16'sd3, 16'sd3);
      send_sample(1'b0, 16'sh8000, 16'sh8000);
      send_sample(1'b1, 16'sd9, -16'sd9);
      send_sample(1'b0, 16'sh7fff, 16'sh8000);
      send_sample(1'b0, 16'sd0, 16'sd0);
   endtask

   // long series past the ring wrap with both sides running flat out
   task automatic test_full_ring_steady();
      drain_results();
      write_window(CSR_SMALL_WINDOW, 8'd1);
      write_window(CSR_LARGE_WINDOW, 8'd128);
      sender_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      send_sample(1'b1, random_sample(), random_sample());
      for (int i = 0; i < 299; i++) begin
         send_sample(1'b0, random_sample(), random_sample());
      end
      drain_results();
      sender_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   task automatic test_random_series();
      for (int phase = 0; phase < 5; phase++) begin
         drain_results();
         if ($urandom_range(1) == 0) begin
            write_window(CSR_SMALL_WINDOW, random_window());
            write_window(CSR_LARGE_WINDOW, random_window());
         end else begin
            write_window(CSR_LARGE_WINDOW, random_window());
            write_window(CSR_SMALL_WINDOW, random_window());
         end
         send_random_series(220);
      end
   endtask

   // rare long stall bursts keep the overall stall share near one cycle in nine
   always @(negedge clock) begin
      if (stall_burst > 0) begin
         stall_burst--;
         rsp_stall <= 1'b1;
      end else if (rsp_idle_on && $urandom_range(99) < 8) begin
         if ($urandom_range(63) == 0) stall_burst = $urandom_range(40, 20);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      window_extremes_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_extremes.size() == 0) begin
            report_mismatch($sformatf("rsp beat %0d with no req beat pending", result_count));
         end else begin
            want = pending_extremes.pop_front();
            check_field("bid_max_long", rsp_bid_max_long, want.bid_max_long);
            check_field("bid_min_long", rsp_bid_min_long, want.bid_min_long);
            check_field("bid_max_short", rsp_bid_max_short, want.bid_max_short);
            check_field("bid_min_short", rsp_bid_min_short, want.bid_min_short);
            check_field("ask_max_long", rsp_ask_max_long, want.ask_max_long);
            check_field("ask_min_long", rsp_ask_min_long, want.ask_min_long);
            check_field("ask_max_short", rsp_ask_max_short, want.ask_max_short);
            check_field("ask_min_short", rsp_ask_min_short, want.ask_min_short);
         end
         result_count++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_enable) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout: no beat for %0d cycles", STALL_LIMIT);
         $display("dual_window_min_max_tracker_top: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      test_reset_windows();
      test_zero_windows();
      test_oversized_windows();
      test_full_ring_steady();
      test_random_series();
      drain_results();
      repeat (40) @(posedge clock);
      if (mismatch_count == 0 && pending_extremes.size() == 0) begin
         $display("dual_window_min_max_tracker_top: match");
      end else begin
         $display("dual_window_min_max_tracker_top: mismatch");
      end
      $finish;
   end

endmodule
